FILE: sv/pwvk_pkg.sv
// Shared types and constants for the plasma wave velocity kick block.
// No dependencies; every other file of the block imports this package.
package pwvk_pkg;

   // Fixed field widths and fixed-point formats
   localparam int WORD_W    = 32;
   localparam int NUM_AXES  = 3;
   localparam int PHASE_W   = 40;   // phase in turns, Q0.40
   localparam int QUARTER_W = 38;   // bits below the quadrant
   localparam int QM_FRAC   = 24;   // fraction bits of charge/mass
   localparam int ADDR_W    = 5;    // six 32-bit registers

   typedef logic signed [WORD_W-1:0] word_type;

   // Configuration register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_WAVE_X = 3'd0,
      REG_WAVE_Y = 3'd1,
      REG_WAVE_Z = 3'd2,
      REG_AMP_X  = 3'd3,
      REG_AMP_Y  = 3'd4,
      REG_AMP_Z  = 3'd5
   } reg_index_type;

   // Register file contents, element 0 is x
   typedef struct packed {
      logic [NUM_AXES-1:0][WORD_W-1:0] wave;
      logic [NUM_AXES-1:0][WORD_W-1:0] amp;
   } cfg_type;

endpackage

FILE: sv/pwvk_csr.sv
// Configuration register file behind an APB-style port.
// Depends on pwvk_pkg for the register index codes and cfg_type.
module pwvk_csr import pwvk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx    = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register writes; addresses beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_WAVE_X: cfg_ff.wave[0] <= csr_pwdata;
            REG_WAVE_Y: cfg_ff.wave[1] <= csr_pwdata;
            REG_WAVE_Z: cfg_ff.wave[2] <= csr_pwdata;
            REG_AMP_X:  cfg_ff.amp[0]  <= csr_pwdata;
            REG_AMP_Y:  cfg_ff.amp[1]  <= csr_pwdata;
            REG_AMP_Z:  cfg_ff.amp[2]  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_WAVE_X: csr_prdata = cfg_ff.wave[0];
         REG_WAVE_Y: csr_prdata = cfg_ff.wave[1];
         REG_WAVE_Z: csr_prdata = cfg_ff.wave[2];
         REG_AMP_X:  csr_prdata = cfg_ff.amp[0];
         REG_AMP_Y:  csr_prdata = cfg_ff.amp[1];
         REG_AMP_Z:  csr_prdata = cfg_ff.amp[2];
         default:    csr_prdata = '0;
      endcase
   end

endmodule

FILE: sv/pwvk_phase.sv
// Phase front end: k.r in turns, quadrant split and cosine table index.
// Stages 1 to 4 of the pipeline. Depends on pwvk_pkg.
module pwvk_phase import pwvk_pkg::*; #(
   parameter  int COS_TABLE_DEPTH = 1024,
   localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic [3:0]       en,
   input  cfg_type          cfg,
   input  word_type         pos_x,
   input  word_type         pos_y,
   input  word_type         pos_z,
   output logic [IDX_W-1:0] idx,
   output logic             neg
);

   localparam int SPLIT = 19;                       // low part of the quarter phase
   localparam int MUL_W = SPLIT + IDX_W;
   localparam int SUM_W = QUARTER_W + IDX_W + 1;
   localparam logic [MUL_W-1:0] D_MUL = MUL_W'(COS_TABLE_DEPTH);
   localparam logic [IDX_W-1:0] D_IDX = IDX_W'(COS_TABLE_DEPTH);

   logic [NUM_AXES-1:0][WORD_W-1:0] pos_w;
   logic signed [2*WORD_W-1:0]      prod_full [NUM_AXES];
   logic [PHASE_W-1:0]              prod_in [NUM_AXES];
   logic [PHASE_W-1:0]              prod_ff [NUM_AXES];
   logic [PHASE_W-1:0]              phase_in, phase_ff;
   logic [MUL_W-1:0]                hi_in, hi_ff, lo_in, lo_ff;
   logic [1:0]                      quad_ff;
   logic [SUM_W-1:0]                idx_sum;
   logic [IDX_W-1:0]                quarter_idx;
   logic [IDX_W-1:0]                idx_in, idx_ff;
   logic                            neg_in, neg_ff;

   assign pos_w = {pos_z, pos_y, pos_x};

   // Stage 1: wave * position per axis, only the 40 fraction bits matter
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_full[a] = (2*WORD_W)'($signed(cfg.wave[a])) *
                        (2*WORD_W)'($signed(pos_w[a]));
         prod_in[a]   = prod_full[a][PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            prod_ff[a] <= prod_in[a];
         end
      end
   end

   // Stage 2: phase modulo one turn
   assign phase_in = prod_ff[0] + prod_ff[1] + prod_ff[2];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         phase_ff <= phase_in;
      end
   end

   // Stage 3: quarter phase times table depth, as two partial products
   assign hi_in = MUL_W'(phase_ff[QUARTER_W-1:SPLIT]) * D_MUL;
   assign lo_in = MUL_W'(phase_ff[SPLIT-1:0]) * D_MUL;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         quad_ff <= phase_ff[PHASE_W-1:QUARTER_W];
      end
   end

   // Stage 4: table index; odd quadrants mirror, quadrants 1 and 2 negate
   assign idx_sum     = (SUM_W'(hi_ff) << SPLIT) + SUM_W'(lo_ff);
   assign quarter_idx = idx_sum[QUARTER_W +: IDX_W];
   assign idx_in      = quad_ff[0] ? (D_IDX - quarter_idx) : quarter_idx;
   assign neg_in      = quad_ff[1] ^ quad_ff[0];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         idx_ff <= idx_in;
         neg_ff <= neg_in;
      end
   end

   assign idx = idx_ff;
   assign neg = neg_ff;

endmodule

FILE: sv/pwvk_cos_rom.sv
// Quarter-wave cosine table, built at elaboration, with a registered read.
// Stage 5 of the pipeline. Depends on pwvk_pkg only through the import.
module pwvk_cos_rom import pwvk_pkg::*; #(
   parameter  int COS_TABLE_DEPTH = 1024,
   parameter  int COS_BITS        = 18,
   localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IDX_W-1:0]    idx,
   output logic [COS_BITS-1:0] mag
);

   localparam int          FRAC        = COS_BITS - 1;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] ONE_Q62     = 64'd1 << 62;
   localparam logic [63:0] DEPTH_U     = 64'(COS_TABLE_DEPTH);
   localparam logic [63:0] X_STEP      = HALF_PI_Q62 / DEPTH_U;
   localparam logic [63:0] X_REM       = HALF_PI_Q62 % DEPTH_U;
   localparam logic [63:0] ROUND_HALF  = 64'd1 << (61 - FRAC);
   localparam logic [63:0] LIMIT       = 64'd1 << FRAC;
   // (2k-1)*2k for the Taylor terms of cos
   localparam logic [63:0] TAYLOR_DIV [1:13] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
   };

   // Q62 product, floored
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // round(cos(pi/2 * i / depth) * 2^FRAC), clipped to [0, 2^FRAC]
   function automatic logic [COS_BITS-1:0] cos_entry(input logic [63:0] i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = X_STEP * i + (X_REM * i) / DEPTH_U;
      x2   = mul_q62(x, x);
      term = ONE_Q62;
      sum  = ONE_Q62;
      for (int k = 1; k <= 13; k++) begin
         term = mul_q62(term, x2) / TAYLOR_DIV[k];
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum[63]) begin
         return '0;
      end
      v = (sum + ROUND_HALF) >> (62 - FRAC);
      if (v > LIMIT) begin
         v = LIMIT;
      end
      return v[COS_BITS-1:0];
   endfunction

   logic [COS_BITS-1:0] table_w [COS_TABLE_DEPTH+1];
   logic [COS_BITS-1:0] mag_ff;

   for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_entry
      localparam logic [COS_BITS-1:0] ENTRY = cos_entry(64'(g));
      assign table_w[g] = ENTRY;
   end

   // Registered lookup
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= table_w[idx];
      end
   end

   assign mag = mag_ff;

endmodule

FILE: sv/pwvk_kick.sv
// One velocity lane: amp*cos, times charge/mass, add and saturate.
// Stages 6 to 9 of the pipeline; stage 9 is the output register. Depends on pwvk_pkg.
module pwvk_kick import pwvk_pkg::*; #(
   parameter int COS_BITS = 18
) (
   input  logic                clock,
   input  logic [3:0]          en,
   input  logic [COS_BITS-1:0] cos_mag,
   input  logic                cos_neg,
   input  word_type            amp,
   input  word_type            qm,
   input  word_type            vel_in,
   output word_type            vel_out,
   output logic                sat
);

   localparam int FRAC = COS_BITS - 1;
   localparam int CW   = COS_BITS + 1;     // signed cosine
   localparam int PW   = WORD_W + CW;      // amp * cos
   localparam int T_W  = WORD_W + 1;       // rounded Q2.30 term, can reach +2^31
   localparam int TQ_W = T_W + WORD_W;     // term * charge/mass
   localparam int V_W  = TQ_W + 1;
   localparam int S_W  = V_W - QM_FRAC;    // unsaturated velocity
   localparam logic signed [PW:0] T_HALF =
      {{(PW-FRAC+1){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
   localparam logic signed [V_W-1:0] D_HALF =
      {{(V_W-QM_FRAC){1'b0}}, 1'b1, {(QM_FRAC-1){1'b0}}};
   localparam word_type VEL_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type VEL_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   logic signed [CW-1:0]   cos_val;
   logic signed [PW-1:0]   ac_in, ac_ff;
   logic signed [PW:0]     t_sum;
   logic signed [T_W-1:0]  t_in, t_ff;
   logic signed [TQ_W-1:0] tq_in, tq_ff;
   logic signed [V_W-1:0]  v_sum;
   logic signed [S_W-1:0]  v_full;
   logic [S_W-WORD_W:0]    v_top;
   word_type               vel_out_in, vel_out_ff;
   logic                   sat_in, sat_ff;

   // Stage 6: signed cosine times amplitude
   assign cos_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
   assign ac_in   = PW'(amp) * PW'(cos_val);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ac_ff <= ac_in;
      end
   end

   // Stage 7: round half up back to Q2.30
   assign t_sum = (PW+1)'(ac_ff) + T_HALF;
   assign t_in  = t_sum[FRAC +: T_W];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t_ff <= t_in;
      end
   end

   // Stage 8: times charge/mass
   assign tq_in = TQ_W'(t_ff) * TQ_W'(qm);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         tq_ff <= tq_in;
      end
   end

   // Stage 9: v + round(tq / 2^24) in one add, then clip to 32 bits
   assign v_sum  = V_W'(tq_ff) + (V_W'(vel_in) <<< QM_FRAC) + D_HALF;
   assign v_full = v_sum[V_W-1:QM_FRAC];
   assign v_top  = v_full[S_W-1:WORD_W-1];

   always_comb begin
      sat_in     = !((&v_top) || !(|v_top));
      vel_out_in = v_full[WORD_W-1:0];
      if (sat_in) begin
         vel_out_in = v_full[S_W-1] ? VEL_MIN : VEL_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         vel_out_ff <= vel_out_in;
         sat_ff     <= sat_in;
      end
   end

   assign vel_out = vel_out_ff;
   assign sat     = sat_ff;

endmodule

FILE: sv/plasma_wave_velocity_kick.sv
// Cosine plane-wave velocity kick: each particle gets v += amp*cos(2*pi*k.r)*q/m
// on x, y and z, saturated to Q2.30. The block is a nine-stage pipeline that
// takes one particle per clock while nothing stalls; its stages are k*r, phase
// sum, quarter phase times table depth, table index, cosine table read,
// amp*cos, rounding, term*q/m and the saturating add, each registered. Each
// stage holds its item under a stall and empty stages keep filling, so the
// input is taken while a result waits in the output register as long as some
// stage is empty. The cosine table is built at elaboration, so there is no
// initialization pass after reset. Registers are written over the APB port
// at byte address 4*i and should only change while the pipeline is empty.
// Depends on pwvk_pkg, pwvk_csr, pwvk_phase, pwvk_cos_rom and pwvk_kick.
module plasma_wave_velocity_kick import pwvk_pkg::*; #(
   parameter int COS_TABLE_DEPTH = 1024,
   parameter int COS_BITS        = 18
) (
   input  logic              clock,
   input  logic              reset,
   // input transactions
   input  logic              req_valid,
   output logic              req_stall,
   input  word_type          req_pos_x,
   input  word_type          req_pos_y,
   input  word_type          req_pos_z,
   input  word_type          req_vel_x_in,
   input  word_type          req_vel_y_in,
   input  word_type          req_vel_z_in,
   input  word_type          req_charge_mass_ratio,
   // result transactions
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output word_type          rsp_vel_x_out,
   output word_type          rsp_vel_y_out,
   output word_type          rsp_vel_z_out,
   output logic              rsp_saturated,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int NUM_STAGES = 9;
   localparam int IDX_W      = $clog2(COS_TABLE_DEPTH + 1);

   cfg_type                         cfg;
   logic [NUM_STAGES:1]             valid_ff;
   logic [NUM_STAGES:1]             valid_chain;
   logic [NUM_STAGES:1]             en;
   logic [NUM_AXES-1:0][WORD_W-1:0] vel_ff [1:8];
   word_type                        qm_ff [1:7];
   logic [IDX_W-1:0]                cos_idx;
   logic                            cos_neg4;
   logic                            cos_neg_ff;
   logic [COS_BITS-1:0]             cos_mag;
   word_type                        vel_out [NUM_AXES];
   logic [NUM_AXES-1:0]             lane_sat;
   logic                            in_acc;
   logic                            out_acc;

   // Register file
   pwvk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stage enables: a stage moves when it is empty or the next one moves
   always_comb begin
      en[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall   = !en[1];
   assign in_acc      = req_valid && !req_stall;
   assign out_acc     = rsp_valid && !rsp_stall;
   assign valid_chain = {valid_ff[NUM_STAGES-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_chain[k];
            end
         end
      end
   end

   // Velocity and charge/mass travel alongside until their lane stage
   always_ff @(posedge clock) begin
      if (en[1]) begin
         vel_ff[1] <= {req_vel_z_in, req_vel_y_in, req_vel_x_in};
         qm_ff[1]  <= req_charge_mass_ratio;
      end
      for (int k = 2; k <= 8; k++) begin
         if (en[k]) begin
            vel_ff[k] <= vel_ff[k-1];
         end
      end
      for (int k = 2; k <= 7; k++) begin
         if (en[k]) begin
            qm_ff[k] <= qm_ff[k-1];
         end
      end
   end

   // Stages 1-4: phase and table index
   pwvk_phase #(
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_phase (
      .clock (clock),
      .en    (en[4:1]),
      .cfg   (cfg),
      .pos_x (req_pos_x),
      .pos_y (req_pos_y),
      .pos_z (req_pos_z),
      .idx   (cos_idx),
      .neg   (cos_neg4)
   );

   // Stage 5: table read, sign kept beside it
   pwvk_cos_rom #(
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
      .COS_BITS        (COS_BITS)
   ) u_cos_rom (
      .clock (clock),
      .en    (en[5]),
      .idx   (cos_idx),
      .mag   (cos_mag)
   );

   always_ff @(posedge clock) begin
      if (en[5]) begin
         cos_neg_ff <= cos_neg4;
      end
   end

   // Stages 6-9: one lane per axis
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      pwvk_kick #(
         .COS_BITS (COS_BITS)
      ) u_kick (
         .clock   (clock),
         .en      (en[9:6]),
         .cos_mag (cos_mag),
         .cos_neg (cos_neg_ff),
         .amp     (cfg.amp[a]),
         .qm      (qm_ff[7]),
         .vel_in  (vel_ff[8][a]),
         .vel_out (vel_out[a]),
         .sat     (lane_sat[a])
      );
   end

   assign rsp_valid     = valid_ff[NUM_STAGES];
   assign rsp_vel_x_out = vel_out[0];
   assign rsp_vel_y_out = vel_out[1];
   assign rsp_vel_z_out = vel_out[2];
   assign rsp_saturated = |lane_sat;

   // A stalled, full tail keeps its item in the stage before the output
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES] && rsp_stall && valid_ff[NUM_STAGES-1] |=>
      valid_ff[NUM_STAGES-1])
   else $error("stage before output lost an item under stall");

   // Items in flight change only by acceptance and delivery
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(valid_ff) ==
      $past($countones(valid_ff)) + $past(32'(in_acc)) - $past(32'(out_acc)))
   else $error("pipeline item count mismatch");

   // A saturated result sits at one of the limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
      (rsp_vel_x_out == {1'b0, {(WORD_W-1){1'b1}}}) ||
      (rsp_vel_x_out == {1'b1, {(WORD_W-1){1'b0}}}) ||
      (rsp_vel_y_out == {1'b0, {(WORD_W-1){1'b1}}}) ||
      (rsp_vel_y_out == {1'b1, {(WORD_W-1){1'b0}}}) ||
      (rsp_vel_z_out == {1'b0, {(WORD_W-1){1'b1}}}) ||
      (rsp_vel_z_out == {1'b1, {(WORD_W-1){1'b0}}}))
   else $error("saturated flag without a clipped component");

endmodule
